FILE: hdl/gacc_pkg.sv
// gacc_pkg: shared types, constants and gf(2^128) helpers for the ghash accumulator
// no dependencies
`default_nettype none
package gacc_pkg;

  localparam int unsigned BLOCK_W    = 128;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned COUNT_IN_W = 5;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned DIGIT_W    = 16;
  localparam int unsigned STEPS      = BLOCK_W / DIGIT_W;
  localparam int unsigned STEP_W     = $clog2(STEPS);
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_H_HIGH = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_H_LOW  = 1'b1;

  localparam logic [BLOCK_W-1:0] REDUCE = {8'hE1, 120'b0};

  typedef struct packed {
    logic [HALF_W-1:0]     block_high;
    logic [HALF_W-1:0]     block_low;
    logic [COUNT_IN_W-1:0] byte_count;
    logic                  first;
    logic                  last;
  } in_item_t;

  typedef struct packed {
    logic [HALF_W-1:0] hash_high;
    logic [HALF_W-1:0] hash_low;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic out_load;
  } gacc_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } gacc_state_t;

  // v * x^j in the reflected bit order, j up to DIGIT_W
  function automatic logic [BLOCK_W-1:0] mul_xpow(input logic [BLOCK_W-1:0] v,
                                                   input int unsigned j);
    logic [BLOCK_W-1:0] res;
    res = v >> j;
    for (int unsigned b = 0; b < DIGIT_W; b++) begin
      if (b < j && v[b]) begin
        res = res ^ (REDUCE >> (j - 1 - b));
      end
    end
    return res;
  endfunction

  // keep the leading bytes, count saturates at a full block
  function automatic logic [BLOCK_W-1:0] byte_mask(input logic [COUNT_IN_W-1:0] count);
    logic [BLOCK_W-1:0] mask;
    mask = '0;
    for (int unsigned i = 0; i < BLOCK_BYTES; i++) begin
      if (COUNT_IN_W'(i) < count) begin
        mask[BLOCK_W-1-8*i -: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/gacc_ctrl.sv
// gacc_ctrl: sequencer for load, digit steps, commit and result hand-off
// depends on gacc_pkg
`default_nettype none
module gacc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gacc_pkg::gacc_cmd_t    cmd
);

  gacc_pkg::gacc_state_t          state, state_next;
  logic [gacc_pkg::STEP_W-1:0]    count, count_next;
  logic                           last_q, last_q_next;
  logic                           out_valid_next;
  logic                           slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gacc_pkg::ST_IDLE;
      count     <= '0;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      last_q    <= last_q_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    last_q_next = last_q;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      gacc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          last_q_next = in_last;
          count_next  = '0;
          state_next  = gacc_pkg::ST_RUN;
        end
      end
      gacc_pkg::ST_RUN: begin
        cmd.step   = 1'b1;
        count_next = count + 1'b1;
        if (count == gacc_pkg::STEP_W'(gacc_pkg::STEPS - 1)) begin
          cmd.commit = 1'b1;
          if (!last_q) begin
            state_next = gacc_pkg::ST_IDLE;
          end else if (slot_free) begin
            cmd.out_load = 1'b1;
            state_next   = gacc_pkg::ST_IDLE;
          end else begin
            state_next = gacc_pkg::ST_HOLD;
          end
        end
      end
      gacc_pkg::ST_HOLD: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = gacc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gacc_pkg::ST_IDLE;
      end
    endcase
    out_valid_next = cmd.out_load || (out_valid && !out_ready);
  end

  a_accept_starts_run: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == gacc_pkg::ST_RUN && count == '0))
    else $error("accepted transaction did not start the multiply");

  a_hold_needs_busy_output: assert property (@(posedge clk) disable iff (rst)
    (state == gacc_pkg::ST_HOLD) |-> out_valid)
    else $error("holding a result while the output slot is empty");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before its transaction");

  a_plain_block_returns: assert property (@(posedge clk) disable iff (rst)
    (state == gacc_pkg::ST_RUN && count == gacc_pkg::STEP_W'(gacc_pkg::STEPS - 1)
     && !last_q) |=> (state == gacc_pkg::ST_IDLE))
    else $error("block without last flag did not return to idle");

endmodule
`default_nettype wire

FILE: hdl/gacc_dp.sv
// gacc_dp: key registers, accumulator and 16-bit digit-serial gf(2^128) multiplier
// depends on gacc_pkg
`default_nettype none
module gacc_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_en,
  input  wire logic [gacc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [gacc_pkg::HALF_W-1:0]       cfg_data,
  input  wire gacc_pkg::in_item_t                in_data,
  input  wire gacc_pkg::gacc_cmd_t               cmd,
  output gacc_pkg::out_item_t                    out_data
);

  logic [gacc_pkg::HALF_W-1:0]  h_high, h_low;
  logic [gacc_pkg::BLOCK_W-1:0] acc;
  logic [gacc_pkg::BLOCK_W-1:0] x, v, r;
  logic [gacc_pkg::BLOCK_W-1:0] r_next, x_in, blk;
  logic [gacc_pkg::BLOCK_W-1:0] hash;

  assign blk  = {in_data.block_high, in_data.block_low} & gacc_pkg::byte_mask(in_data.byte_count);
  assign x_in = (in_data.first ? '0 : acc) ^ blk;

  always_comb begin
    r_next = r;
    for (int unsigned j = 0; j < gacc_pkg::DIGIT_W; j++) begin
      if (x[gacc_pkg::BLOCK_W-1-j]) begin
        r_next = r_next ^ gacc_pkg::mul_xpow(v, j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_high <= '0;
      h_low  <= '0;
      acc    <= '0;
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          gacc_pkg::REG_H_HIGH: h_high <= cfg_data;
          gacc_pkg::REG_H_LOW:  h_low  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        acc <= r_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x <= x_in;
      v <= {h_high, h_low};
      r <= '0;
    end else if (cmd.step) begin
      x <= x << gacc_pkg::DIGIT_W;
      v <= gacc_pkg::mul_xpow(v, gacc_pkg::DIGIT_W);
      r <= r_next;
    end
    if (cmd.out_load) begin
      hash <= cmd.commit ? r_next : acc;
    end
  end

  assign out_data.hash_high = hash[gacc_pkg::BLOCK_W-1:gacc_pkg::HALF_W];
  assign out_data.hash_low  = hash[gacc_pkg::HALF_W-1:0];

endmodule
`default_nettype wire

FILE: hdl/ghash_accumulator_unit.sv
// ghash_accumulator_unit: top level of the ghash accumulator
// depends on gacc_pkg, gacc_ctrl, gacc_dp
// Each accepted block is masked to its byte count and xored with the accumulator
// (with zero if first is set) to form the multiplier operand, folded in 16 bits
// per cycle against the hash key. Unless a hash must wait, the next block is taken
// in the cycle after the last digit step, only once the one before is through. A
// last-flag block puts its hash in an output register to wait for its transaction
// while the next block is worked on; the unit stalls only if a second hash
// is ready before the first is taken. The user must write the key registers
// through the cfg port while no block is in flight; the unit does not enforce it.
`default_nettype none
module ghash_accumulator_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_en,
  input  wire logic [gacc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [gacc_pkg::HALF_W-1:0]       cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire gacc_pkg::in_item_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output gacc_pkg::out_item_t                    out_data
);

  gacc_pkg::gacc_cmd_t cmd;

  gacc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  gacc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
